// ===== hdl/sha512_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 shared definitions
// Round constants, initial hash values, the controller/datapath command and
// status types, and the small word functions of the compression round.
// ----------------------------------------------------------------------------
package sha512_pkg;

	localparam int unsigned ROUNDS  = 80;
	localparam int unsigned ROUND_W = $clog2(ROUNDS);
	localparam int unsigned WIN_LEN = 16;
	localparam int unsigned HASH_N  = 8;
	localparam int unsigned OIDX_W  = $clog2(HASH_N);
	localparam int unsigned FILL_W  = $clog2(WIN_LEN);

	typedef logic [63:0] word_t;

	localparam word_t PAD_WORD = 64'h8000_0000_0000_0000;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [3:0] FULL_BYTES = 4'd8;

	localparam word_t ROUND_K [ROUNDS] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	localparam word_t INIT_HASH [HASH_N] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	// Source of the word shifted into the message window.
	typedef enum logic [2:0] {
		PUSH_DATA,
		PUSH_PAD,
		PUSH_ZERO,
		PUSH_LENHI,
		PUSH_LENLO
	} push_sel_t;

	// Controller to datapath.
	typedef struct packed {
		logic                push_en;
		push_sel_t           push_sel;
		logic                count_en;
		logic                round_en;
		logic [ROUND_W-1:0]  round_idx;
		logic                fold_en;
		logic                chain_reset;
		logic [OIDX_W-1:0]   out_idx;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic fill_last;
		logic fill_14;
		logic fill_zero;
	} stat_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	// Keeps the leading nb bytes, places the pad byte right after them and
	// clears the rest. With nb equal to eight the word passes unchanged.
	function automatic word_t pad_last_word(input word_t data, input logic [3:0] nb);
		word_t res;
		res = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < nb) begin
				res[63-8*b -: 8] = data[63-8*b -: 8];
			end else if (4'(b) == nb) begin
				res[63-8*b -: 8] = PAD_BYTE;
			end
		end
		pad_last_word = res;
	endfunction

endpackage

// ===== hdl/sha512_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 stream interfaces
// Valid/ready channels for message words in and digest words out.
// ----------------------------------------------------------------------------
interface sha512_msg_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  valid_bytes;
	logic        last_word;

	modport source (output valid, output data_word, output valid_bytes, output last_word,
		input ready);
	modport sink (input valid, input data_word, input valid_bytes, input last_word,
		output ready);
endinterface

interface sha512_digest_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic        digest_last;

	modport source (output valid, output digest_word, output digest_last, input ready);
	modport sink (input valid, input digest_word, input digest_last, output ready);
endinterface

// ===== hdl/sha512_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 datapath
// Message window, round variables, chaining value and 128-bit byte count.
// One push or one compression round per cycle, under controller command.
// ----------------------------------------------------------------------------
module sha512_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  sha512_pkg::cmd_t    cmd,
	input  logic [63:0]         data_word,
	input  logic [3:0]          valid_bytes,
	input  logic                last_word,
	output sha512_pkg::stat_t   stat,
	output logic [63:0]         digest_word
);

	sha512_pkg::word_t win_q   [sha512_pkg::WIN_LEN];
	sha512_pkg::word_t vars_q  [sha512_pkg::HASH_N];
	sha512_pkg::word_t chain_q [sha512_pkg::HASH_N];
	logic [127:0] count_q;
	logic [sha512_pkg::FILL_W-1:0] fill_q;

	logic [3:0]        nb_sat;
	logic [3:0]        add_bytes;
	sha512_pkg::word_t push_word;
	sha512_pkg::word_t next_w;
	sha512_pkg::word_t t1;
	sha512_pkg::word_t t2;
	sha512_pkg::word_t ch;
	sha512_pkg::word_t maj;

	// Byte count of the current word, saturated at a full word.
	assign nb_sat    = (valid_bytes > sha512_pkg::FULL_BYTES) ? sha512_pkg::FULL_BYTES
		: valid_bytes;
	assign add_bytes = last_word ? nb_sat : sha512_pkg::FULL_BYTES;

	// Word pushed into the window.
	always_comb begin
		case (cmd.push_sel)
			sha512_pkg::PUSH_DATA:  push_word = last_word
				? sha512_pkg::pad_last_word(data_word, nb_sat) : data_word;
			sha512_pkg::PUSH_PAD:   push_word = sha512_pkg::PAD_WORD;
			sha512_pkg::PUSH_LENHI: push_word = count_q[124:61];
			sha512_pkg::PUSH_LENLO: push_word = {count_q[60:0], 3'b000};
			default:                push_word = '0;
		endcase
	end

	// Message schedule: the window holds W[t..t+15], the next word enters at the top.
	assign next_w = sha512_pkg::small_sigma1(win_q[14]) + win_q[9]
		+ sha512_pkg::small_sigma0(win_q[1]) + win_q[0];

	// Round function.
	assign ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
	assign maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
	assign t1  = vars_q[7] + sha512_pkg::big_sigma1(vars_q[4]) + ch
		+ sha512_pkg::ROUND_K[cmd.round_idx] + win_q[0];
	assign t2  = sha512_pkg::big_sigma0(vars_q[0]) + maj;

	// Window shifts on a push or a round.
	always_ff @(posedge clk) begin
		if (cmd.push_en || cmd.round_en) begin
			for (int i = 0; i < sha512_pkg::WIN_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[sha512_pkg::WIN_LEN-1] <= cmd.push_en ? push_word : next_w;
		end
	end

	// Round variables load from the chain when a push completes a block.
	always_ff @(posedge clk) begin
		if (cmd.push_en && stat.fill_last) begin
			for (int i = 0; i < sha512_pkg::HASH_N; i++) begin
				vars_q[i] <= chain_q[i];
			end
		end else if (cmd.round_en) begin
			vars_q[7] <= vars_q[6];
			vars_q[6] <= vars_q[5];
			vars_q[5] <= vars_q[4];
			vars_q[4] <= vars_q[3] + t1;
			vars_q[3] <= vars_q[2];
			vars_q[2] <= vars_q[1];
			vars_q[1] <= vars_q[0];
			vars_q[0] <= t1 + t2;
		end
	end

	// Chaining value, byte count and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sha512_pkg::HASH_N; i++) begin
				chain_q[i] <= sha512_pkg::INIT_HASH[i];
			end
			count_q <= '0;
			fill_q  <= '0;
		end else begin
			if (cmd.chain_reset) begin
				for (int i = 0; i < sha512_pkg::HASH_N; i++) begin
					chain_q[i] <= sha512_pkg::INIT_HASH[i];
				end
				count_q <= '0;
			end else begin
				if (cmd.fold_en) begin
					for (int i = 0; i < sha512_pkg::HASH_N; i++) begin
						chain_q[i] <= chain_q[i] + vars_q[i];
					end
				end
				if (cmd.count_en) begin
					count_q <= count_q + 128'(add_bytes);
				end
			end
			if (cmd.push_en) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign stat.fill_last = (fill_q == sha512_pkg::FILL_W'(sha512_pkg::WIN_LEN - 1));
	assign stat.fill_14   = (fill_q == sha512_pkg::FILL_W'(sha512_pkg::WIN_LEN - 2));
	assign stat.fill_zero = (fill_q == '0);

	assign digest_word = chain_q[cmd.out_idx];

endmodule

// ===== hdl/sha512_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 controller
// Sequences word pushes, padding, length words, the 80 rounds, the chain
// update and the eight digest transactions.
// ----------------------------------------------------------------------------
module sha512_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [3:0]         valid_bytes,
	input  logic               last_word,
	output logic               in_ready,
	output logic               out_valid,
	output logic               out_last,
	input  logic               out_ready,
	input  sha512_pkg::stat_t  stat,
	output sha512_pkg::cmd_t   cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_FIN  = 5'b00010,
		ST_COMP = 5'b00100,
		ST_FOLD = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   fin_q, fin_d;
	logic   pad_q, pad_d;
	logic   lenhi_q, lenhi_d;
	logic   lenlo_q, lenlo_d;
	logic [sha512_pkg::ROUND_W-1:0] round_q, round_d;
	logic [sha512_pkg::OIDX_W-1:0]  oidx_q, oidx_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_last  = (oidx_q == sha512_pkg::OIDX_W'(sha512_pkg::HASH_N - 1));

	// Next state and command decode.
	always_comb begin
		cmd           = '0;
		cmd.push_sel  = sha512_pkg::PUSH_DATA;
		cmd.round_idx = round_q;
		cmd.out_idx   = oidx_q;
		state_d       = state_q;
		fin_d         = fin_q;
		pad_d         = pad_q;
		lenhi_d       = lenhi_q;
		lenlo_d       = lenlo_q;
		round_d       = round_q;
		oidx_d        = oidx_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.push_en  = 1'b1;
					cmd.count_en = 1'b1;
					if (last_word) begin
						fin_d   = 1'b1;
						pad_d   = (valid_bytes >= sha512_pkg::FULL_BYTES);
						lenhi_d = 1'b0;
						lenlo_d = 1'b0;
					end
					if (stat.fill_last) begin
						state_d = ST_COMP;
					end else if (last_word) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				// Pad word when the last word was full, zero fill, then the two length words.
				cmd.push_en = 1'b1;
				if (pad_q) begin
					cmd.push_sel = sha512_pkg::PUSH_PAD;
					pad_d        = 1'b0;
				end else if (stat.fill_last && lenhi_q) begin
					cmd.push_sel = sha512_pkg::PUSH_LENLO;
					lenlo_d      = 1'b1;
				end else if (stat.fill_14 && !lenhi_q) begin
					cmd.push_sel = sha512_pkg::PUSH_LENHI;
					lenhi_d      = 1'b1;
				end else begin
					cmd.push_sel = sha512_pkg::PUSH_ZERO;
				end
				if (stat.fill_last) begin
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				cmd.round_en = 1'b1;
				if (round_q == sha512_pkg::ROUND_W'(sha512_pkg::ROUNDS - 1)) begin
					round_d = '0;
					state_d = ST_FOLD;
				end else begin
					round_d = round_q + 1'b1;
				end
			end
			ST_FOLD: begin
				cmd.fold_en = 1'b1;
				if (!fin_q) begin
					state_d = ST_IDLE;
				end else if (lenlo_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					oidx_d = oidx_q + 1'b1;
					if (out_last) begin
						cmd.chain_reset = 1'b1;
						fin_d           = 1'b0;
						state_d         = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q   <= 1'b0;
			pad_q   <= 1'b0;
			lenhi_q <= 1'b0;
			lenlo_q <= 1'b0;
			round_q <= '0;
			oidx_q  <= '0;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
			pad_q   <= pad_d;
			lenhi_q <= lenhi_d;
			lenlo_q <= lenlo_d;
			round_q <= round_d;
			oidx_q  <= oidx_d;
		end
	end

endmodule

// ===== hdl/sha512_stream_hasher.sv =====
`timescale 1ns / 1ps
// A message word is pushed into the window; a word that completes a 128-byte block is
// followed by the 80 rounds and the chain update. The last word adds padding pushes and
// one or two compressions before eight digest transactions, one per cycle when taken.
// Input words are not taken while a block is compressed or the digest is sent; the
// single round unit runs one round per cycle.
// Reset loads the initial hash values and clears the byte count and fill level.
// ----------------------------------------------------------------------------
// SHA-512 stream hasher
// Hashes a word stream with FIPS 180-4 SHA-512 and returns the eight digest
// words after the word flagged as last.
// ----------------------------------------------------------------------------
module sha512_stream_hasher (
	input  logic                   clk,
	input  logic                   arst_n,
	sha512_msg_if.sink             msg,
	sha512_digest_if.source        digest
);

	sha512_pkg::cmd_t  cmd;
	sha512_pkg::stat_t stat;

	sha512_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (msg.valid),
		.valid_bytes (msg.valid_bytes),
		.last_word   (msg.last_word),
		.in_ready    (msg.ready),
		.out_valid   (digest.valid),
		.out_last    (digest.digest_last),
		.out_ready   (digest.ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	sha512_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_word   (msg.data_word),
		.valid_bytes (msg.valid_bytes),
		.last_word   (msg.last_word),
		.stat        (stat),
		.digest_word (digest.digest_word)
	);

	// The input side never opens while digest words are pending.
	assert property (@(posedge clk) disable iff (!arst_n) !(msg.ready && digest.valid))
		else $error("input ready while digest output is valid");

	// Digest words only come out after the length word closed the block.
	assert property (@(posedge clk) disable iff (!arst_n) digest.valid |-> stat.fill_zero)
		else $error("digest output with a partially filled block");

	// After the final digest transaction the block is ready for a new message.
	assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid && digest.ready && digest.digest_last |=> msg.ready)
		else $error("not ready after the final digest transaction");

	// A word that neither ends the message nor fills the block leaves the input ready in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		msg.valid && msg.ready && !msg.last_word && !stat.fill_last |=> msg.ready)
		else $error("stalled after a plain message word");

endmodule
